// ===== hw/rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared sizes, codes and the queued word format of the region permission
// table
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

    localparam int MAX_REGIONS = 8;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 32;
    localparam int PERM_W      = 8;
    localparam int END_W       = ADDR_W + 1;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TDATA_W   = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd4;

    typedef enum logic [2:0] {
        K_ADD,
        K_ADD_BAD,
        K_REMOVE,
        K_CHECK,
        K_INVALID
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [END_W-1:0]   span_end;
        logic [PERM_W-1:0]  perm;
    } t_item;

endpackage

`default_nettype wire

// ===== hw/rtl/mrpt_front.sv =====
// ----------------------------------------------------------------------------
// mrpt_front
// accepts input words, decodes the opcode, screens zero address and length
// and forms the 33-bit span end, then hands a classified word to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [mrpt_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire  [mrpt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           o_valid,
    input  wire                            i_ready,
    output mrpt_pkg::t_item                o_item
);
    import mrpt_pkg::*;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [PERM_W-1:0] perm;
    logic              bad;

    assign addr = s_tdata[ADDR_W-1:0];
    assign len  = s_tdata[ADDR_W+LEN_W-1:ADDR_W];
    assign perm = s_tdata[ADDR_W+LEN_W+PERM_W-1:ADDR_W+LEN_W];
    assign bad  = (addr == '0) || (len == '0);

    always_comb begin
        n_item.addr     = addr;
        n_item.span_end = {1'b0, addr} + {1'b0, len};
        n_item.perm     = perm;
        case (s_tuser)
            OP_ADD:    n_item.kind = bad ? K_ADD_BAD : K_ADD;
            OP_REMOVE: n_item.kind = (addr == '0) ? K_INVALID : K_REMOVE;
            OP_CHECK:  n_item.kind = bad ? K_INVALID : K_CHECK;
            default:   n_item.kind = K_INVALID;
        endcase
    end

    assign s_tready = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrpt_queue.sv =====
// ----------------------------------------------------------------------------
// mrpt_queue
// short first-in first-out buffer of classified words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    output logic            o_ready,
    input  mrpt_pkg::t_item i_item,
    output logic            o_valid,
    input  wire             i_pop,
    output mrpt_pkg::t_item o_item
);
    import mrpt_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrpt_back.sv =====
// ----------------------------------------------------------------------------
// mrpt_back
// holds the region table; compares every region against the queued word in
// parallel, then picks the first match, commits the table change and
// registers the status word
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_pop,
    input  mrpt_pkg::t_item                i_item,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [mrpt_pkg::M_TDATA_W-1:0] m_tdata
);
    import mrpt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_start [MAX_REGIONS];
    logic [END_W-1:0]      r_end   [MAX_REGIONS];
    logic [PERM_W-1:0]     r_perm  [MAX_REGIONS];
    t_item                 r_item;
    logic [MAX_REGIONS-1:0] r_hit;
    logic [MAX_REGIONS-1:0] r_pok;
    logic [MAX_REGIONS-1:0] r_smatch;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;

    logic [MAX_REGIONS-1:0] n_hit;
    logic [MAX_REGIONS-1:0] n_pok;
    logic [MAX_REGIONS-1:0] n_smatch;
    logic [IDX_W-1:0]      hidx;
    logic [IDX_W-1:0]      sidx;
    logic                  full;
    logic                  fire;
    logic [STATUS_W-1:0]   status;

    // parallel region compare against the queue head
    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            n_hit[i]    = (CNT_W'(i) < r_count) &&
                          (i_item.addr >= r_start[i]) &&
                          (i_item.span_end <= r_end[i]);
            n_pok[i]    = ((r_perm[i] & i_item.perm) == i_item.perm);
            n_smatch[i] = (CNT_W'(i) < r_count) && (r_start[i] == i_item.addr);
        end
    end

    // first set bit wins
    always_comb begin
        hidx = '0;
        sidx = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hidx = IDX_W'(i);
            end
            if (r_smatch[i]) begin
                sidx = IDX_W'(i);
            end
        end
    end

    assign full  = (r_count >= CNT_W'(MAX_REGIONS));
    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign fire  = (r_state == S_EXEC) && (!r_out_valid || m_tready);

    always_comb begin
        case (r_item.kind)
            K_ADD:     status = full ? ST_NO_SPACE : ST_OK;
            K_ADD_BAD: status = full ? ST_NO_SPACE : ST_INVALID;
            K_REMOVE:  status = (|r_smatch) ? ST_OK : ST_NOT_FOUND;
            K_CHECK:   status = ((|r_hit) && r_pok[hidx]) ? ST_OK : ST_DENIED;
            default:   status = ST_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                    if (m_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_status    <= status;
                        if (r_item.kind == K_ADD && !full) begin
                            r_count <= r_count + 1'b1;
                        end else if (r_item.kind == K_REMOVE && (|r_smatch)) begin
                            r_count <= r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_item;
            r_hit    <= n_hit;
            r_pok    <= n_pok;
            r_smatch <= n_smatch;
        end
        if (fire && r_item.kind == K_ADD && !full) begin
            r_start[r_count[IDX_W-1:0]] <= r_item.addr;
            r_end[r_count[IDX_W-1:0]]   <= r_item.span_end;
            r_perm[r_count[IDX_W-1:0]]  <= r_item.perm;
        end
        if (fire && r_item.kind == K_REMOVE && (|r_smatch)) begin
            for (int j = 0; j < MAX_REGIONS - 1; j++) begin
                if (IDX_W'(j) >= sidx) begin
                    r_start[j] <= r_start[j+1];
                    r_end[j]   <= r_end[j+1];
                    r_perm[j]  <= r_perm[j+1];
                end
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W){1'b0}}, r_status};

endmodule

`default_nettype wire

// ===== hw/rtl/memory_region_permission_table_core.sv =====
// ----------------------------------------------------------------------------
// memory_region_permission_table_core
// ordered table of memory regions with add, remove and access check
//
// channel   dir  signals                         word
// s_        in   s_tvalid s_tready s_tdata s_tuser  one command
// m_        out  m_tvalid m_tready m_tdata         one status
//
// the back end works each word as a parallel compare of all regions, then
// first-match pick and table commit; it takes a new word only once the
// status of the last one is registered; a command passes the front register,
// the queue, the compare registers and the status register in that order.
// reset clears the region count at once, no clearing pass.
// a stalled status holds the back end; the front and a 2-word queue keep
// accepting meanwhile until they fill.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_region_permission_table_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // addr[31:0], span_size[63:32], perm_bits[71:64]
    input  wire  [mrpt_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  wire  [mrpt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // status[2:0], zero fill [7:3]
    output logic [mrpt_pkg::M_TDATA_W-1:0] m_tdata
);
    import mrpt_pkg::*;

    logic  f_valid;
    logic  q_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    mrpt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .o_valid  (f_valid),
        .i_ready  (q_ready),
        .o_item   (f_item)
    );

    mrpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    mrpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mrpt_checker.sv =====
// ----------------------------------------------------------------------------
// mrpt_checker
// port-level checks on the region permission table status stream
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [mrpt_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire [mrpt_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [mrpt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mrpt_pkg::*;

    // no status word straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("status word valid right after reset");

    // waiting command word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("command word changed while waiting");

    // stalled status word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("status word changed under stall");

    // only defined status codes appear
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[2:0] != 3'd5) && (m_tdata[2:0] != 3'd6) &&
                     (m_tdata[2:0] != 3'd7))
        else $error("undefined status code");

    // fill bits stay zero
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'd0))
        else $error("status fill bits set");

endmodule

bind memory_region_permission_table_core mrpt_checker u_mrpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
